// ----- design/ibd_pkg.sv -----
// Package for the IMU UART burst deframer: status codes, register indexes,
// framing constants and the result record. No dependencies.
`timescale 1ns / 1ps

package ibd_pkg;

    localparam int BYTE_W      = 8;
    localparam int RAW_W       = 32;
    localparam int SUM_W       = 16;
    localparam int FL_W        = 6;
    localparam int CFG_DATA_W  = 6;
    localparam int CFG_IDX_W   = 1;
    localparam int MIN_LEN     = 4;
    localparam int N_VALUES    = 6;
    localparam int VAL_BYTES   = 8 * 3;

    localparam logic [BYTE_W-1:0] HDR_BYTE   = 8'h80;
    localparam logic [BYTE_W-1:0] DELIM_BYTE = 8'h0D;

    localparam logic [FL_W-1:0] FRAME_LENGTH_RST = 6'd26;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECKSUM_ENABLE = 1'd1;

    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_OK       = 2'd1,
        ST_BAD_SUM  = 2'd2,
        ST_NO_DELIM = 2'd3
    } t_status;

    typedef struct packed {
        t_status                  status;
        logic signed [RAW_W-1:0]  gyro_x_raw;
        logic signed [RAW_W-1:0]  gyro_y_raw;
        logic signed [RAW_W-1:0]  gyro_z_raw;
        logic signed [RAW_W-1:0]  accel_x_raw;
        logic signed [RAW_W-1:0]  accel_y_raw;
        logic signed [RAW_W-1:0]  accel_z_raw;
    } t_result;

endpackage

// ----- design/ibd_byte_if.sv -----
// Byte input channel of the deframer: valid/ready handshake and one byte.
// Depends on ibd_pkg for the byte width.
`timescale 1ns / 1ps

interface ibd_byte_if
    import ibd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

// ----- design/ibd_result_if.sv -----
// Result channel of the deframer: valid/ready handshake, status and six raw values.
// Depends on ibd_pkg for the field widths.
`timescale 1ns / 1ps

interface ibd_result_if
    import ibd_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic signed [RAW_W-1:0] gyro_x_raw;
    logic signed [RAW_W-1:0] gyro_y_raw;
    logic signed [RAW_W-1:0] gyro_z_raw;
    logic signed [RAW_W-1:0] accel_x_raw;
    logic signed [RAW_W-1:0] accel_y_raw;
    logic signed [RAW_W-1:0] accel_z_raw;

    modport source (
        output valid, output status,
        output gyro_x_raw, output gyro_y_raw, output gyro_z_raw,
        output accel_x_raw, output accel_y_raw, output accel_z_raw,
        input ready
    );
    modport sink (
        input valid, input status,
        input gyro_x_raw, input gyro_y_raw, input gyro_z_raw,
        input accel_x_raw, input accel_y_raw, input accel_z_raw,
        output ready
    );
endinterface

// ----- design/imu_uart_burst_deframer_core.sv -----
// Top level of the IMU UART burst deframer: byte framing, word-sum check and
// value extraction. Depends on ibd_pkg, ibd_byte_if, ibd_result_if and ibd_out_skid.
`timescale 1ns / 1ps

// The deframer takes one received UART byte per transaction and returns exactly one
// result transaction for every byte, in order. A header byte 0x80 restarts the
// frame at any position. The next frame_length bytes (clamped to 4..MAX_FRAME_BYTES)
// are stored, and the byte after them must be the delimiter 0x0D: status 3 reports
// a missing delimiter, status 2 a failed 16-bit big-endian word sum (when
// checksum_enable is set) and status 1 a good frame, which carries three gyro and
// three accel signed 32-bit big-endian values from frame bytes 0 to 23. All other
// results have status 0 and zero values. A byte can be accepted on every clock while
// the skid entry is free: the decision for a byte is made combinationally from the
// running count, the running word sum and the two checksum bytes, and the result
// is registered in the output register, or in the skid entry while a result waits
// for the sink, so the block can take another byte meanwhile. The frame buffer is a
// two-read-port RAM whose checksum bytes are read ahead into registers at addresses
// set by the frame length, with forwarding of the byte being written; the value bytes
// sit in their own registers. The buffer needs no clearing pass after reset, and
// the configuration registers take effect for the byte after the write.
module imu_uart_burst_deframer_core
    import ibd_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ibd_byte_if.sink              i_byte,
    ibd_result_if.source          o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int LW = $clog2(MAX_FRAME_BYTES + 1);
    localparam int AW = $clog2(MAX_FRAME_BYTES);

    // Clamp the programmed length into the supported range.
    function automatic logic [LW-1:0] f_used_len(input logic [FL_W-1:0] fl);
        logic [LW-1:0] v;
        if (int'(fl) < MIN_LEN) begin
            v = LW'(MIN_LEN);
        end else if (int'(fl) > MAX_FRAME_BYTES) begin
            v = LW'(MAX_FRAME_BYTES);
        end else begin
            v = LW'(fl);
        end
        return v;
    endfunction

    // Configuration registers.
    logic [FL_W-1:0] r_frame_length;
    logic [FL_W-1:0] n_frame_length;
    logic            r_checksum_enable;
    logic            n_checksum_enable;

    // Frame state.
    logic [LW-1:0]     r_cnt;
    logic [LW-1:0]     n_cnt;
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  n_sum;
    logic [BYTE_W-1:0] r_prev;

    // Checksum bytes, read ahead from the buffer into registers.
    logic [BYTE_W-1:0] r_mem [MAX_FRAME_BYTES];
    logic [BYTE_W-1:0] r_chk_hi;
    logic [BYTE_W-1:0] r_chk_lo;

    logic [LW-1:0]     w_len;
    logic [LW-1:0]     w_len_next;
    logic [AW-1:0]     w_rd_hi;
    logic [AW-1:0]     w_rd_lo;
    logic [AW-1:0]     w_wr_addr;
    logic              w_accept;
    logic              w_is_hdr;
    logic              w_store;
    logic              w_sum_add;
    logic [BYTE_W-1:0] w_b;
    logic [BYTE_W-1:0] w_vb [VAL_BYTES];
    t_result           n_res;
    t_result           w_out;
    logic              w_in_ready;

    assign w_b        = i_byte.byte_in;
    assign w_accept   = i_byte.valid && w_in_ready;
    assign w_len      = f_used_len(r_frame_length);
    assign w_is_hdr   = (w_b == HDR_BYTE);
    assign w_store    = !w_is_hdr && (r_cnt < w_len);
    assign w_wr_addr  = r_cnt[AW-1:0];
    // A byte at an odd index closes a word, unless that word is the checksum.
    assign w_sum_add  = r_cnt[0] && (({1'b0, r_cnt} + (LW+1)'(2)) <= {1'b0, w_len});

    // Configuration writes.
    always_comb begin
        n_frame_length    = r_frame_length;
        n_checksum_enable = r_checksum_enable;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_LENGTH:    n_frame_length    = i_cfg_data[FL_W-1:0];
                CFG_CHECKSUM_ENABLE: n_checksum_enable = i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_length    <= FRAME_LENGTH_RST;
            r_checksum_enable <= 1'b1;
        end else begin
            r_frame_length    <= n_frame_length;
            r_checksum_enable <= n_checksum_enable;
        end
    end

    // Frame count and running word sum.
    always_comb begin
        n_cnt = r_cnt;
        n_sum = r_sum;
        if (w_accept) begin
            if (w_store) begin
                n_cnt = r_cnt + LW'(1);
                if (w_sum_add) begin
                    n_sum = r_sum + {r_prev, w_b};
                end
            end else begin
                // Header, delimiter check or framing error: the frame restarts.
                n_cnt = '0;
                n_sum = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_sum <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_sum <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_store) begin
            r_prev <= w_b;
        end
    end

    // Frame buffer RAM. The read addresses follow the length that holds after
    // this edge, and a byte written at this edge is forwarded to the read data.
    assign w_len_next = f_used_len(n_frame_length);
    assign w_rd_hi    = AW'(w_len_next - LW'(2));
    assign w_rd_lo    = AW'(w_len_next - LW'(1));

    always_ff @(posedge i_clk) begin
        if (w_accept && w_store) begin
            r_mem[w_wr_addr] <= w_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_store && (w_wr_addr == w_rd_hi)) begin
            r_chk_hi <= w_b;
        end else begin
            r_chk_hi <= r_mem[w_rd_hi];
        end
        if (w_accept && w_store && (w_wr_addr == w_rd_lo)) begin
            r_chk_lo <= w_b;
        end else begin
            r_chk_lo <= r_mem[w_rd_lo];
        end
    end

    // Value bytes live in registers of their own; positions past the buffer read zero.
    for (genvar i = 0; i < VAL_BYTES; i++) begin : g_vb
        if (i < MAX_FRAME_BYTES) begin : g_reg
            logic [BYTE_W-1:0] r_byte;
            always_ff @(posedge i_clk) begin
                if (w_accept && w_store && (r_cnt == LW'(i))) begin
                    r_byte <= w_b;
                end
            end
            assign w_vb[i] = r_byte;
        end else begin : g_zero
            assign w_vb[i] = '0;
        end
    end

    // Result of the current byte.
    always_comb begin
        n_res        = '0;
        n_res.status = ST_NONE;
        if (!w_is_hdr && !w_store) begin
            if (w_b != DELIM_BYTE) begin
                n_res.status = ST_NO_DELIM;
            end else if (r_checksum_enable && (r_sum != {r_chk_hi, r_chk_lo})) begin
                n_res.status = ST_BAD_SUM;
            end else begin
                n_res.status      = ST_OK;
                n_res.gyro_x_raw  = {w_vb[0],  w_vb[1],  w_vb[2],  w_vb[3]};
                n_res.gyro_y_raw  = {w_vb[4],  w_vb[5],  w_vb[6],  w_vb[7]};
                n_res.gyro_z_raw  = {w_vb[8],  w_vb[9],  w_vb[10], w_vb[11]};
                n_res.accel_x_raw = {w_vb[12], w_vb[13], w_vb[14], w_vb[15]};
                n_res.accel_y_raw = {w_vb[16], w_vb[17], w_vb[18], w_vb[19]};
                n_res.accel_z_raw = {w_vb[20], w_vb[21], w_vb[22], w_vb[23]};
            end
        end
    end

    ibd_out_skid u_out_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_byte.valid),
        .o_ready (w_in_ready),
        .i_data  (n_res),
        .o_valid (o_result.valid),
        .i_ready (o_result.ready),
        .o_data  (w_out)
    );

    assign i_byte.ready         = w_in_ready;
    assign o_result.status      = w_out.status;
    assign o_result.gyro_x_raw  = w_out.gyro_x_raw;
    assign o_result.gyro_y_raw  = w_out.gyro_y_raw;
    assign o_result.gyro_z_raw  = w_out.gyro_z_raw;
    assign o_result.accel_x_raw = w_out.accel_x_raw;
    assign o_result.accel_y_raw = w_out.accel_y_raw;
    assign o_result.accel_z_raw = w_out.accel_z_raw;

    // The byte count never runs past the buffer.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_cnt) <= MAX_FRAME_BYTES)
        else $error("byte count beyond buffer depth");

    // A header byte always restarts the count and the word sum.
    a_hdr_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_hdr) |=> (r_cnt == '0) && (r_sum == '0))
        else $error("header did not restart the frame");

    // A stored byte advances the count by one.
    a_store_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_store) |=> (r_cnt == $past(r_cnt) + LW'(1)))
        else $error("stored byte did not advance the count");

endmodule

// ----- design/ibd_out_skid.sv -----
// Output register with one skid entry for deframer results.
// Depends on ibd_pkg for the result record.
`timescale 1ns / 1ps

module ibd_out_skid
    import ibd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out_data;
    t_result r_skid_data;

    // Upstream is held back only when the skid entry is in use.
    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_valid;
            end
        end else if (i_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_ready) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else begin
                r_out_data <= i_data;
            end
        end else if (i_valid && !r_skid_valid) begin
            r_skid_data <= i_data;
        end
    end

endmodule

// ----- bench/imu_uart_burst_deframer_core_tb.sv -----
// Self-checking testbench for imu_uart_burst_deframer_core: byte stream in, one
// result per byte out, checked against a cycle-free model of the deframer.
// Depends on ibd_pkg, ibd_byte_if, ibd_result_if and the deframer RTL.
`timescale 1ns / 1ps

module imu_uart_burst_deframer_core_tb
    import ibd_pkg::*;
();

    // Scoreboard: keeps its own copy of the deframer state and configuration,
    // predicts the result of every accepted byte and checks results in order.
    class deframe_scoreboard;
        logic [FL_W-1:0]   frame_len_reg;
        logic              sum_check_on;
        int unsigned       stored_bytes;
        logic [SUM_W-1:0]  word_total;
        logic [BYTE_W-1:0] frame_mem [32];
        t_result           awaited_results [$];
        int unsigned       errors;

        function new();
            frame_len_reg = FRAME_LENGTH_RST;
            sum_check_on  = 1'b1;
            stored_bytes  = 0;
            word_total    = '0;
            errors        = 0;
            foreach (frame_mem[i]) frame_mem[i] = '0;
        endfunction

        // Programmed length clamped to the range the block supports.
        function int unsigned eff_len();
            if (frame_len_reg < MIN_LEN) return MIN_LEN;
            if (frame_len_reg > 32) return 32;
            return frame_len_reg;
        endfunction

        function int unsigned pending();
            return awaited_results.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_FRAME_LENGTH) frame_len_reg = data[FL_W-1:0];
            else if (idx == CFG_CHECKSUM_ENABLE) sum_check_on = data[0];
        endfunction

        function logic [RAW_W-1:0] be_word(int unsigned at);
            return {frame_mem[at], frame_mem[at+1], frame_mem[at+2], frame_mem[at+3]};
        endfunction

        // Works out the result of one accepted byte and queues it.
        function void note_byte(logic [BYTE_W-1:0] b);
            t_result          r;
            int unsigned      len;
            logic [SUM_W-1:0] chk;
            r = '0;
            r.status = ST_NONE;
            len = eff_len();
            if (b == HDR_BYTE) begin
                stored_bytes = 0;
                word_total   = '0;
            end else if (stored_bytes < len) begin
                frame_mem[stored_bytes] = b;
                if ((stored_bytes % 2) == 1 && stored_bytes + 2 <= len)
                    word_total = word_total + {frame_mem[stored_bytes-1], b};
                stored_bytes++;
            end else begin
                if (b != DELIM_BYTE) begin
                    r.status = ST_NO_DELIM;
                end else begin
                    chk = {frame_mem[len-2], frame_mem[len-1]};
                    if (sum_check_on && word_total != chk) begin
                        r.status = ST_BAD_SUM;
                    end else begin
                        r.status      = ST_OK;
                        r.gyro_x_raw  = be_word(0);
                        r.gyro_y_raw  = be_word(4);
                        r.gyro_z_raw  = be_word(8);
                        r.accel_x_raw = be_word(12);
                        r.accel_y_raw = be_word(16);
                        r.accel_z_raw = be_word(20);
                    end
                end
                stored_bytes = 0;
                word_total   = '0;
            end
            awaited_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [RAW_W-1:0] want,
                                    logic [RAW_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (awaited_results.size() == 0) begin
                $error("result with no byte waiting for it: status %0d", got.status);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            compare_field("status", RAW_W'(want.status), RAW_W'(got.status));
            compare_field("gyro_x_raw", want.gyro_x_raw, got.gyro_x_raw);
            compare_field("gyro_y_raw", want.gyro_y_raw, got.gyro_y_raw);
            compare_field("gyro_z_raw", want.gyro_z_raw, got.gyro_z_raw);
            compare_field("accel_x_raw", want.accel_x_raw, got.accel_x_raw);
            compare_field("accel_y_raw", want.accel_y_raw, got.accel_y_raw);
            compare_field("accel_z_raw", want.accel_z_raw, got.accel_z_raw);
        endfunction
    endclass

    // Ways in which a generated frame can be spoiled on purpose.
    typedef enum int {
        FLAW_NONE,
        FLAW_BAD_SUM,
        FLAW_NO_DELIM,
        FLAW_CUT_SHORT,
        FLAW_HDR_AT_DELIM
    } t_frame_flaw;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ibd_byte_if   byte_ch ();
    ibd_result_if res_ch ();

    imu_uart_burst_deframer_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (byte_ch),
        .o_result    (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    deframe_scoreboard sb = new();

    // Idling controls. tx_gaps and rx_gaps turn the random bubbles on each side
    // on or off; rx_hold_left, when loaded, makes the receiver refuse results while
    // it counts down to zero, so that the block fills up and back-pressures its input.
    bit          tx_gaps = 1'b1;
    bit          rx_gaps = 1'b1;
    int          rx_hold_left = 0;
    int unsigned tx_count = 0;

    // Body of the frame that is about to be sent: data bytes, then the two
    // checksum bytes at the end of the programmed length.
    logic [BYTE_W-1:0] frame_body [32];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Generous simulation-time limit: far beyond the slowest correct run.
    initial begin
        #1_000_000;
        $display("simulation failed");
        $finish;
    end

    // Receiver side. Ready changes only at the falling edge, so the block sees a
    // stable value at every rising edge.
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                res_ch.ready = 1'b0;
                rx_hold_left--;
            end else if (rx_gaps) begin
                res_ch.ready = ($urandom_range(99) >= 30);
            end else begin
                res_ch.ready = 1'b1;
            end
        end
    end

    // Every result transaction is checked at the rising edge where it is taken.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.status      = t_status'(res_ch.status);
            got.gyro_x_raw  = res_ch.gyro_x_raw;
            got.gyro_y_raw  = res_ch.gyro_y_raw;
            got.gyro_z_raw  = res_ch.gyro_z_raw;
            got.accel_x_raw = res_ch.accel_x_raw;
            got.accel_y_raw = res_ch.accel_y_raw;
            got.accel_z_raw = res_ch.accel_z_raw;
            sb.check_result(got);
        end
    end

    // Offers one byte and waits for the transaction. Entered and left at a falling
    // edge; valid stays high afterward so back-to-back bytes need no bubble.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (tx_gaps && $urandom_range(99) < 30) begin
            byte_ch.valid = 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge i_clk);
        end
        byte_ch.valid   = 1'b1;
        byte_ch.byte_in = b;
        do @(posedge i_clk); while (!byte_ch.ready);
        sb.note_byte(b);
        tx_count++;
        @(negedge i_clk);
    endtask

    // Stops sending and waits until every byte has produced its result, then idles
    // a little so that the block is truly idle before a register write.
    task automatic wait_drained();
        byte_ch.valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    // Any byte except the header, which would restart the frame.
    function automatic logic [BYTE_W-1:0] data_byte();
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom_range(255));
        if (b == HDR_BYTE) b = b ^ 8'h01;
        return b;
    endfunction

    // A byte that is neither the header nor the delimiter.
    function automatic logic [BYTE_W-1:0] wrong_delim();
        logic [BYTE_W-1:0] b;
        b = data_byte();
        if (b == DELIM_BYTE) b = 8'h00;
        return b;
    endfunction

    task automatic fill_body();
        foreach (frame_body[i]) frame_body[i] = data_byte();
    endtask

    // Sends header, body and delimiter. For an even length the last two body bytes
    // are replaced by the big-endian word sum of the words before them; odd lengths
    // keep random check bytes and pass only with the check switched off. A check
    // byte that happens to equal the header simply restarts the frame.
    task automatic send_frame(input int unsigned len, input t_frame_flaw flaw);
        logic [SUM_W-1:0] total;
        int unsigned      cut;
        if (len % 2 == 0) begin
            total = '0;
            for (int i = 0; i + 3 <= len; i += 2)
                total = total + {frame_body[i], frame_body[i+1]};
            frame_body[len-2] = total[15:8];
            frame_body[len-1] = total[7:0];
        end
        if (flaw == FLAW_BAD_SUM) begin
            frame_body[len-1] = frame_body[len-1] ^ 8'h01;
            if (frame_body[len-1] == HDR_BYTE) frame_body[len-1] = HDR_BYTE ^ 8'h03;
        end
        cut = (flaw == FLAW_CUT_SHORT) ? $urandom_range(len - 1) : len;
        send_byte(HDR_BYTE);
        for (int i = 0; i < cut; i++) send_byte(frame_body[i]);
        if (cut < len) return;
        case (flaw)
            FLAW_NO_DELIM:     send_byte(wrong_delim());
            FLAW_HDR_AT_DELIM: send_byte(HDR_BYTE);
            default:           send_byte(DELIM_BYTE);
        endcase
    endtask

    // Random traffic for one configuration: mostly well-formed frames with random
    // content, some spoiled frames and some raw noise that may contain header and
    // delimiter bytes anywhere.
    task automatic random_traffic(input int unsigned n_bytes);
        int unsigned start;
        int unsigned pick;
        int unsigned burst;
        start = tx_count;
        while (tx_count - start < n_bytes) begin
            pick = $urandom_range(99);
            fill_body();
            if (pick < 55) begin
                send_frame(sb.eff_len(), FLAW_NONE);
            end else if (pick < 65) begin
                send_frame(sb.eff_len(), FLAW_BAD_SUM);
            end else if (pick < 73) begin
                send_frame(sb.eff_len(), FLAW_NO_DELIM);
            end else if (pick < 80) begin
                send_frame(sb.eff_len(), FLAW_CUT_SHORT);
            end else if (pick < 85) begin
                send_frame(sb.eff_len(), FLAW_HDR_AT_DELIM);
            end else begin
                burst = $urandom_range(1, 6);
                repeat (burst) begin
                    case ($urandom_range(5))
                        0:       send_byte(HDR_BYTE);
                        1:       send_byte(DELIM_BYTE);
                        default: send_byte(BYTE_W'($urandom_range(255)));
                    endcase
                end
            end
        end
    endtask

    // Frame length and check enable for each random phase. The lengths include the
    // clamped extremes (0 and 63), the bounds 4 and 32, odd lengths and lengths
    // shorter than the value area; one phase draws its length at random.
    int unsigned len_plan [10] = '{4, 32, 0, 63, 5, 24, 33, 12, 18, 26};
    bit          sum_plan [10] = '{1, 1, 0, 1, 0, 1, 1, 1, 0, 1};

    initial begin
        logic [CFG_DATA_W-1:0] fl;
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        byte_ch.valid   = 1'b0;
        byte_ch.byte_in = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed part at the reset settings (length 26, check on). This first
        // full frame also writes every byte of the value area, so later short
        // frames never read a buffer entry that was never written. Its values hit
        // the extremes: all ones, the largest positive, zero and a large negative.
        fill_body();
        for (int i = 0; i < 4; i++) frame_body[i] = 8'hFF;
        frame_body[4] = 8'h7F;
        for (int i = 5; i < 8; i++) frame_body[i] = 8'hFF;
        for (int i = 8; i < 12; i++) frame_body[i] = 8'h00;
        frame_body[12] = 8'h81;
        for (int i = 13; i < 16; i++) frame_body[i] = 8'h00;
        send_frame(26, FLAW_NONE);

        // Shortest length: a good short frame whose first value comes from its own bytes
        // and the others from the frame before, then a header where the delimiter is due.
        write_cfg(CFG_FRAME_LENGTH, CFG_DATA_W'(4));
        fill_body();
        send_frame(4, FLAW_NONE);
        fill_body();
        send_frame(4, FLAW_HDR_AT_DELIM);

        // Random phases. Each register write happens with the block drained,
        // which is also the point where the sender waits for every result; a
        // phase that ended mid-frame carries its byte count into the new length.
        for (int p = 0; p < 10; p++) begin
            tx_gaps = !(p == 4 || p == 5);
            rx_gaps = !(p == 5 || p == 6);
            fl = (p == 7) ? CFG_DATA_W'($urandom_range(63)) : CFG_DATA_W'(len_plan[p]);
            write_cfg(CFG_FRAME_LENGTH, fl);
            write_cfg(CFG_CHECKSUM_ENABLE,
                      {(CFG_DATA_W-1)'($urandom_range(31)), sum_plan[p]});
            // Long receiver stall while the sender keeps offering bytes: the output
            // register and the skid entry fill, and the input must stall.
            if (p == 2) rx_hold_left = 300;
            random_traffic(50);
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/ibd_pkg.sv
design/ibd_byte_if.sv
design/ibd_result_if.sv
design/ibd_out_skid.sv
design/imu_uart_burst_deframer_core.sv
bench/imu_uart_burst_deframer_core_tb.sv
